// File: src/samr_pkg.sv
// Shared widths, constants and the DAC level table of the stereo mixer/resampler.
`timescale 1ns / 1ps
`default_nettype none
package samr_pkg;

  // Field widths
  localparam int ADV_W      = 8;
  localparam int LEVEL_W    = 4;
  localparam int NUM_CH     = 4;
  localparam int VOL_W      = 3;
  localparam int ROUTE_W    = 8;
  localparam int SAMPLE_W   = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_POWER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LVOL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RVOL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROUTE  = 2'd3;

  // Datapath widths (signal is Q8.24)
  localparam int CH_W   = 26;   // one DAC value
  localparam int SUM_W  = 28;   // sum of four DAC values
  localparam int IN_W   = 28;   // filter input after volume
  localparam int CHG_W  = 32;   // filter output and charge
  localparam int WIDE_W = 40;   // differences before saturation

  // Shared multiplier
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 21;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Filter and sample scaling
  localparam logic signed [MUL_B_W-1:0] CHARGE_K = 21'sd65296;   // 0.996337 in Q0.16
  localparam logic signed [MUL_B_W-1:0] SAMPLE_K = 21'sd65534;
  localparam logic signed [MUL_B_W-1:0] RECIP_11 = 21'sd762601;  // ceil(2^23 / 11)
  localparam int HP_SHIFT    = 16;
  localparam int VOL_SHIFT   = 3;
  localparam int Y_LSB       = 24;
  localparam int Y_W         = 24;
  localparam int RECIP_SHIFT = 23;
  localparam int Q_W         = 15;
  localparam logic [Y_W-1:0] Y_CLAMP = 24'd360448;               // 11 * 32768

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // Pairs per input word
  localparam logic [1:0] MAX_PAIRS = 2'd3;
  localparam logic [1:0] LAST_SLOT = 2'd2;

  typedef logic signed [CH_W-1:0] dac_t;

  // (2L-15) * 2^24 / 15, rounded to nearest
  function automatic dac_t dac_value(input logic [LEVEL_W-1:0] level);
    dac_t v;
    case (level)
      4'd0:    v = -26'sd16777216;
      4'd1:    v = -26'sd14540254;
      4'd2:    v = -26'sd12303292;
      4'd3:    v = -26'sd10066330;
      4'd4:    v = -26'sd7829367;
      4'd5:    v = -26'sd5592405;
      4'd6:    v = -26'sd3355443;
      4'd7:    v = -26'sd1118481;
      4'd8:    v = 26'sd1118481;
      4'd9:    v = 26'sd3355443;
      4'd10:   v = 26'sd5592405;
      4'd11:   v = 26'sd7829367;
      4'd12:   v = 26'sd10066330;
      4'd13:   v = 26'sd12303292;
      4'd14:   v = 26'sd14540254;
      default: v = 26'sd16777216;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: src/samr_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module samr_mul (
  input  logic                                  clk_i,
  input  logic signed [samr_pkg::MUL_A_W-1:0]   a_i,
  input  logic signed [samr_pkg::MUL_B_W-1:0]   b_i,
  output logic signed [samr_pkg::PROD_W-1:0]    p_o
);
  import samr_pkg::*;

  logic signed [PROD_W-1:0] prod_d;

  // full-width signed product
  assign prod_d = PROD_W'(a_i) * PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    p_o <= prod_d;
  end

endmodule
`default_nettype wire

// File: src/stereo_audio_mixer_resampler.sv
// Top level of the four-channel stereo mixer with resampler and DC-blocking high-pass.
//
// Input stream (s_axis_*): one word per master clock advance, carrying the advance,
// four channel levels and the DAC enable bits. The phase accumulator decides how
// many stereo pairs (0 to 3) the word causes; each pair leaves on m_axis_* with
// left and right samples, tlast set on the final pair of the word.
// Config channel (cfg_*): always ready; writes are expected only while idle.
// Sequence: one shared multiplier under a sequencer does all arithmetic. A word that
// causes no pair passes the add and check steps; each pair adds, with power on, 9 steps
// of the multiplier sequence per side plus check and push, and only check and push with
// power off. Each dropped pair beyond three repeats the check step to reduce the phase.
// s_axis_tready_o is high only while the sequencer is idle.
// Output: one output register; the sequencer waits in its push step while the
// receiver stalls and a previous pair is still held, and the next input word can
// be taken while the final pair waits.
// Reset: control registers, the phase accumulator and both filter charges clear, and
// the block comes up powered off; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module stereo_audio_mixer_resampler #(
  parameter int OUTPUT_RATE       = 48000,
  parameter int MASTER_CLOCK_RATE = 4194304
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // clock_advance, level_one, level_two, level_three, level_four, dac_enables
  input  logic [samr_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // left_sample, right_sample
  output logic [samr_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  output logic                                m_axis_tlast_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [samr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [samr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import samr_pkg::*;

  localparam int PH_W  = $clog2(MASTER_CLOCK_RATE);
  localparam int ACC_W = $clog2(MASTER_CLOCK_RATE + ((1 << ADV_W) - 1) * OUTPUT_RATE + 1);
  localparam int T_W   = PROD_W - HP_SHIFT;

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_ADD   = 13'b0000000000010,
    ST_CHECK = 13'b0000000000100,
    ST_SUM   = 13'b0000000001000,
    ST_VOL   = 13'b0000000010000,
    ST_DIV8  = 13'b0000000100000,
    ST_HPOUT = 13'b0000001000000,
    ST_MULK  = 13'b0000010000000,
    ST_CHG   = 13'b0000100000000,
    ST_MAG   = 13'b0001000000000,
    ST_MULR  = 13'b0010000000000,
    ST_SAMP  = 13'b0100000000000,
    ST_PUSH  = 13'b1000000000000
  } state_e;

  function automatic logic signed [CHG_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [CHG_W-1:0] r;
    if ((&v[WIDE_W-1:CHG_W-1]) || !(|v[WIDE_W-1:CHG_W-1])) begin
      r = v[CHG_W-1:0];
    end else if (v[WIDE_W-1]) begin
      r = {1'b1, {(CHG_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(CHG_W-1){1'b1}}};
    end
    return r;
  endfunction

  state_e state_q, state_d;

  // configuration
  logic               power_q, power_d;
  logic [VOL_W-1:0]   lvol_q, lvol_d, rvol_q, rvol_d;
  logic [ROUTE_W-1:0] route_q, route_d;

  // resampler
  logic [PH_W-1:0]  phase_q, phase_d;
  logic [ACC_W-1:0] acc_q, acc_d, acc_sub;
  logic [1:0]       cnt_q, cnt_d;
  logic             last_q, last_d;
  logic             side_q, side_d;

  // captured input word
  logic [LEVEL_W-1:0] lvl_q [NUM_CH];
  logic [NUM_CH-1:0]  en_q;

  // datapath registers
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic signed [IN_W-1:0]     in_q, in_d;
  logic signed [CHG_W-1:0]    out_q, out_d;
  logic signed [CHG_W-1:0]    lchg_q, lchg_d, rchg_q, rchg_d;
  logic [Y_W-1:0]             y_q, y_d;
  logic                       neg_q, neg_d;
  logic signed [SAMPLE_W-1:0] lsmp_q, lsmp_d, rsmp_q, rsmp_d;

  // output register
  logic                       ovalid_q, ovalid_d;
  logic                       olast_q, olast_d;
  logic [OUT_DATA_W-1:0]      odata_q, odata_d;

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_q;

  logic in_fire, out_free, cfg_fire;
  logic signed [CH_W-1:0]   ch_val [NUM_CH];
  logic [NUM_CH-1:0]        side_mask;
  logic [VOL_W-1:0]         side_vol;
  logic signed [CHG_W-1:0]  side_chg;
  logic signed [PROD_W-1:0] vol_rnd, hp_rnd;
  logic signed [T_W-1:0]    hp_t;
  logic [PROD_W-1:0]        prod_mag;
  logic [SAMPLE_W-1:0]      q_ext;
  logic signed [SAMPLE_W-1:0] smp;
  logic signed [CHG_W-1:0]  chg_new;

  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign out_free        = !ovalid_q || m_axis_tready_i;
  assign cfg_ready_o     = 1'b1;
  assign cfg_fire        = cfg_valid_i && cfg_ready_o;

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tdata_o  = odata_q;

  // per-channel DAC values of the held word
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      ch_val[i] = en_q[i] ? dac_value(lvl_q[i]) : '0;
    end
  end

  // side selection: left takes route bits 7:4, right bits 3:0
  assign side_mask = side_q ? route_q[NUM_CH-1:0] : route_q[ROUTE_W-1:NUM_CH];
  assign side_vol  = side_q ? rvol_q : lvol_q;
  assign side_chg  = side_q ? rchg_q : lchg_q;

  // multiplier operand select
  always_comb begin
    mul_a = {{(MUL_A_W-ADV_W){1'b0}}, s_axis_tdata_i[ADV_W-1:0]};
    mul_b = MUL_B_W'(OUTPUT_RATE);
    unique case (state_q)
      ST_VOL: begin
        mul_a = MUL_A_W'(sum_q);
        mul_b = MUL_B_W'({1'b0, side_vol} + 4'd1);
      end
      ST_MULK: begin
        mul_a = MUL_A_W'(out_q);
        mul_b = CHARGE_K;
      end
      ST_CHG: begin
        mul_a = MUL_A_W'(out_q);
        mul_b = SAMPLE_K;
      end
      ST_MULR: begin
        mul_a = {{(MUL_A_W-Y_W){1'b0}}, y_q};
        mul_b = RECIP_11;
      end
      default: ;
    endcase
  end

  samr_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod_q)
  );

  // arithmetic helpers around the product
  always_comb begin
    vol_rnd  = prod_q + (prod_q[PROD_W-1] ? PROD_W'((1 << VOL_SHIFT) - 1) : '0);
    hp_rnd   = prod_q + PROD_W'(1 << (HP_SHIFT - 1));
    hp_t     = hp_rnd[PROD_W-1:HP_SHIFT];
    chg_new  = sat32(WIDE_W'(in_q) - WIDE_W'(hp_t));
    prod_mag = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
    q_ext    = {1'b0, prod_q[RECIP_SHIFT+Q_W-1:RECIP_SHIFT]};
    if (y_q >= Y_CLAMP) begin
      smp = neg_q ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      smp = neg_q ? -$signed(q_ext) : $signed(q_ext);
    end
  end

  assign acc_sub = acc_q - ACC_W'(MASTER_CLOCK_RATE);

  // sequencer
  always_comb begin
    state_d  = state_q;
    power_d  = power_q;
    lvol_d   = lvol_q;
    rvol_d   = rvol_q;
    route_d  = route_q;
    phase_d  = phase_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    last_d   = last_q;
    side_d   = side_q;
    sum_d    = sum_q;
    in_d     = in_q;
    out_d    = out_q;
    lchg_d   = lchg_q;
    rchg_d   = rchg_q;
    y_d      = y_q;
    neg_d    = neg_q;
    lsmp_d   = lsmp_q;
    rsmp_d   = rsmp_q;
    ovalid_d = ovalid_q;
    olast_d  = olast_q;
    odata_d  = odata_q;

    // receiver drains the output register
    if (ovalid_q && m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end

    // register writes; power off clears volumes and routing
    if (cfg_fire) begin
      unique case (cfg_index_i)
        REG_POWER: begin
          power_d = cfg_data_i[0];
          if (!cfg_data_i[0]) begin
            lvol_d  = '0;
            rvol_d  = '0;
            route_d = '0;
          end
        end
        REG_LVOL:  if (power_q) lvol_d = cfg_data_i[VOL_W-1:0];
        REG_RVOL:  if (power_q) rvol_d = cfg_data_i[VOL_W-1:0];
        REG_ROUTE: if (power_q) route_d = cfg_data_i[ROUTE_W-1:0];
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cnt_d   = '0;
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        acc_d   = ACC_W'(phase_q) + prod_q[ACC_W-1:0];
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (acc_q >= ACC_W'(MASTER_CLOCK_RATE)) begin
          acc_d = acc_sub;
          if (cnt_q < MAX_PAIRS) begin
            cnt_d  = cnt_q + 2'd1;
            last_d = (cnt_q == LAST_SLOT) || (acc_sub < ACC_W'(MASTER_CLOCK_RATE));
            side_d = 1'b0;
            if (power_q) begin
              state_d = ST_SUM;
            end else begin
              lsmp_d  = '0;
              rsmp_d  = '0;
              state_d = ST_PUSH;
            end
          end
        end else begin
          phase_d = acc_q[PH_W-1:0];
          state_d = ST_IDLE;
        end
      end
      ST_SUM: begin
        sum_d = '0;
        for (int i = 0; i < NUM_CH; i++) begin
          if (side_mask[i]) sum_d = sum_d + SUM_W'(ch_val[i]);
        end
        state_d = ST_VOL;
      end
      ST_VOL: begin
        state_d = ST_DIV8;
      end
      ST_DIV8: begin
        // divide by 8, truncating toward zero
        in_d    = vol_rnd[IN_W+VOL_SHIFT-1:VOL_SHIFT];
        state_d = ST_HPOUT;
      end
      ST_HPOUT: begin
        out_d   = sat32(WIDE_W'(in_q) - WIDE_W'(side_chg));
        state_d = ST_MULK;
      end
      ST_MULK: begin
        state_d = ST_CHG;
      end
      ST_CHG: begin
        if (side_q) rchg_d = chg_new;
        else        lchg_d = chg_new;
        state_d = ST_MAG;
      end
      ST_MAG: begin
        neg_d   = prod_q[PROD_W-1];
        y_d     = prod_mag[Y_LSB+Y_W-1:Y_LSB];
        state_d = ST_MULR;
      end
      ST_MULR: begin
        state_d = ST_SAMP;
      end
      ST_SAMP: begin
        if (side_q) begin
          rsmp_d  = smp;
          state_d = ST_PUSH;
        end else begin
          lsmp_d  = smp;
          side_d  = 1'b1;
          state_d = ST_SUM;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          olast_d  = last_q;
          odata_d  = {rsmp_q, lsmp_q};
          state_d  = ST_CHECK;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      power_q  <= 1'b0;
      lvol_q   <= '0;
      rvol_q   <= '0;
      route_q  <= '0;
      phase_q  <= '0;
      acc_q    <= '0;
      cnt_q    <= '0;
      side_q   <= 1'b0;
      lchg_q   <= '0;
      rchg_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      power_q  <= power_d;
      lvol_q   <= lvol_d;
      rvol_q   <= rvol_d;
      route_q  <= route_d;
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      side_q   <= side_d;
      lchg_q   <= lchg_d;
      rchg_q   <= rchg_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    last_q  <= last_d;
    sum_q   <= sum_d;
    in_q    <= in_d;
    out_q   <= out_d;
    y_q     <= y_d;
    neg_q   <= neg_d;
    lsmp_q  <= lsmp_d;
    rsmp_q  <= rsmp_d;
    olast_q <= olast_d;
    odata_q <= odata_d;
    if (in_fire) begin
      for (int i = 0; i < NUM_CH; i++) begin
        lvl_q[i] <= s_axis_tdata_i[ADV_W+LEVEL_W*i +: LEVEL_W];
      end
      en_q <= s_axis_tdata_i[ADV_W+LEVEL_W*NUM_CH +: NUM_CH];
    end
  end

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ACC_W'(phase_q) < ACC_W'(MASTER_CLOCK_RATE))
    else $error("phase accumulator out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH && out_free) |=> (m_axis_tvalid_o && state_q == ST_CHECK))
    else $error("pair not loaded into output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> power_q)
    else $error("filter path active while powered off");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD) |-> (cnt_q == '0))
    else $error("pair count not cleared at new word");

endmodule
`default_nettype wire
